// ===== rtl/rtdm_pkg.sv =====
// Shared types and constants for the tick delay manager.
package rtdm_pkg;
  localparam int MaxTasks = 64;
  localparam int DelayBits = 32;
  localparam int IdxBits = 6;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 6;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_DELAY = 3'd1;
  localparam logic [2:0] OP_RESUME = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;
  localparam logic [2:0] OP_STEP = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_NOT_DELAYED = 3'd3;
  localparam logic [2:0] ST_FROM_ISR = 3'd4;
  localparam logic [2:0] ST_LOCKED = 3'd5;

  localparam logic [1:0] PRESENT = 2'd2;

  localparam logic [1:0] STEP_OFF = 2'd0;
  localparam logic [1:0] STEP_WAIT = 2'd1;
  localparam logic [1:0] STEP_ONCE = 2'd2;

  localparam logic [CfgIdxBits-1:0] REG_LOWEST = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_RUNNING = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_TIME_EN = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] task_index;
    logic [31:0] delay_ticks;
    logic in_interrupt;
    logic scheduler_locked;
    logic [1:0] presence_value;
    logic pending_value;
    logic suspended_value;
    logic [1:0] step_request;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] ready_groups;
    logic reschedule;
    logic [6:0] expired_count;
    logic [31:0] system_time;
  } rsp_t;

  // one task table entry
  typedef struct packed {
    logic [DelayBits-1:0] delay;
    logic [1:0] presence;
    logic pending;
    logic suspended;
    logic timed_out;
  } task_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic exec;       // run the captured request
    logic walk;       // process entry at idx
    logic clear;      // zero entry at idx
    logic rd_walk;    // read table at rd_idx instead of the request index
    logic [IdxBits-1:0] idx;
    logic [IdxBits-1:0] rd_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic do_walk;
  } sts_t;
endpackage

// ===== rtl/rtdm_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface rtdm_req_if;
  import rtdm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtdm_rsp_if;
  import rtdm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rtdm_ctrl.sv =====
// Controller: clears the task table after reset, sequences one transaction and the tick walk over all tasks.
module rtdm_ctrl (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input logic out_ready,
  input rtdm_pkg::sts_t sts,
  output rtdm_pkg::cmd_t cmd
);
  import rtdm_pkg::*;
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_OUT} state_t;
  localparam logic [IdxBits-1:0] LastTask = IdxBits'(MaxTasks - 1);
  state_t state;
  logic [IdxBits-1:0] idx;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.exec = (state == S_EXEC);
    cmd.walk = (state == S_WALK);
    cmd.clear = (state == S_CLEAR);
    cmd.rd_walk = (state != S_IDLE);
    cmd.idx = idx;
    cmd.rd_idx = (state == S_WALK) ? idx + 1'b1 : idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == LastTask) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          idx <= '0;
          state <= S_EXEC;
        end
        S_EXEC: state <= sts.do_walk ? S_WALK : S_OUT;
        S_WALK: begin
          idx <= idx + 1'b1;
          if (idx == LastTask) state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/rtdm_datapath.sv =====
// Datapath: task tables, ready bitmap, time counter and single-task operations.
module rtdm_datapath (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [rtdm_pkg::CfgIdxBits-1:0] cfg_index,
  input logic [rtdm_pkg::CfgDataBits-1:0] cfg_data,
  input rtdm_pkg::req_t req,
  input rtdm_pkg::cmd_t cmd,
  output rtdm_pkg::sts_t sts,
  output rtdm_pkg::rsp_t rsp
);
  import rtdm_pkg::*;
  localparam logic [31:0] DelayMax = 32'((64'd1 << DelayBits) - 64'd1);

  task_t task_mem [MaxTasks];
  task_t rd_data;
  task_t wr_data;
  logic wr_en;
  logic [IdxBits-1:0] wr_addr, rd_addr, qi;
  logic [MaxTasks-1:0] ready;
  logic ready_we, ready_val;
  logic [1:0] step_state;
  logic [31:0] tick_time;
  logic [5:0] lowest;
  logic running, time_en;
  req_t req_q;
  logic idx_ok;
  logic [DelayBits-1:0] dsat;
  logic [2:0] status, ex_status;
  logic resched, ex_resched;
  logic walk_expire;
  logic [6:0] expired;
  logic [7:0] groups;

  always_comb begin
    groups = '0;
    for (int g = 0; g < MaxTasks / 8; g++) groups[g] = |ready[g*8 +: 8];
  end

  assign sts.do_walk = (req_q.opcode == OP_TICK) && running && (step_state != STEP_WAIT);
  assign rsp.status = status;
  assign rsp.ready_groups = groups;
  assign rsp.reschedule = resched;
  assign rsp.expired_count = expired;
  assign rsp.system_time = tick_time;

  assign qi = req_q.task_index;
  assign idx_ok = ({1'b0, qi} < (IdxBits + 1)'(MaxTasks));
  assign rd_addr = cmd.rd_walk ? cmd.rd_idx : req.task_index;
  assign dsat = DelayBits'((req_q.delay_ticks > DelayMax) ? DelayMax : req_q.delay_ticks);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = cmd.idx;
    wr_data = rd_data;
    ready_we = 1'b0;
    ready_val = 1'b0;
    ex_status = ST_OK;
    ex_resched = 1'b0;
    walk_expire = 1'b0;
    if (cmd.clear) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (cmd.walk) begin
      if (cmd.idx != lowest && rd_data.presence == PRESENT && rd_data.delay != '0) begin
        wr_en = 1'b1;
        wr_data.delay = rd_data.delay - 1'b1;
        if (rd_data.delay == DelayBits'(1)) begin
          walk_expire = 1'b1;
          wr_data.timed_out = rd_data.pending;
          wr_data.pending = 1'b0;
          if (!rd_data.suspended) begin
            ready_we = 1'b1;
            ready_val = 1'b1;
          end
        end
      end
    end else if (cmd.exec) begin
      wr_addr = qi;
      case (req_q.opcode)
        OP_DELAY: begin
          if (req_q.in_interrupt) ex_status = ST_FROM_ISR;
          else if (req_q.scheduler_locked) ex_status = ST_LOCKED;
          else if (!idx_ok) ex_status = ST_BAD_INDEX;
          else if (req_q.delay_ticks != 32'd0) begin
            wr_en = 1'b1;
            wr_data.delay = dsat;
            ready_we = 1'b1;
            ready_val = 1'b0;
            ex_resched = 1'b1;
          end
        end
        OP_RESUME: begin
          if (!idx_ok || qi >= lowest) ex_status = ST_BAD_INDEX;
          else if (rd_data.presence != PRESENT) ex_status = ST_ABSENT;
          else if (rd_data.delay == '0) ex_status = ST_NOT_DELAYED;
          else begin
            wr_en = 1'b1;
            wr_data.delay = '0;
            wr_data.timed_out = rd_data.pending;
            wr_data.pending = 1'b0;
            if (!rd_data.suspended) begin
              ready_we = 1'b1;
              ready_val = 1'b1;
              ex_resched = 1'b1;
            end
          end
        end
        OP_STATUS: begin
          if (!idx_ok) ex_status = ST_BAD_INDEX;
          else begin
            wr_en = 1'b1;
            wr_data.presence = req_q.presence_value;
            wr_data.pending = req_q.pending_value;
            wr_data.suspended = req_q.suspended_value;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= task_mem[rd_addr];
    if (wr_en) task_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
      step_state <= STEP_OFF;
      tick_time <= '0;
      lowest <= 6'd63;
      running <= 1'b0;
      time_en <= 1'b1;
      req_q <= '0;
      status <= ST_OK;
      resched <= 1'b0;
      expired <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOWEST: lowest <= cfg_data;
          REG_RUNNING: running <= cfg_data[0];
          REG_TIME_EN: time_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        req_q <= req;
        status <= ST_OK;
        resched <= 1'b0;
        expired <= '0;
      end
      if (cmd.exec) begin
        status <= ex_status;
        resched <= ex_resched;
        case (req_q.opcode)
          OP_TICK: begin
            if (time_en) tick_time <= tick_time + 1'b1;
            if (running) begin
              case (step_state)
                STEP_OFF: ;
                STEP_WAIT: ;
                STEP_ONCE: step_state <= STEP_WAIT;
                default: step_state <= STEP_OFF;
              endcase
            end
          end
          OP_STEP: step_state <= req_q.step_request;
          default: ;
        endcase
      end
      if (walk_expire) expired <= expired + 1'b1;
      if (ready_we) ready[wr_addr] <= ready_val;
    end
  end
endmodule

// ===== rtl/rtos_tick_delay_manager_core.sv =====
// Top level of the tick delay manager.
// One transaction at a time. After reset the block zeroes its task table
// and holds req.ready low. A request runs the cycle after it is accepted; a
// tick with the kernel running and stepping not in wait then walks the 64 task
// entries at one per cycle before its result is offered. Every other operation
// offers its result without a walk. The next request is accepted at the
// earliest in the cycle after the result is taken. A result register holds the
// response until taken.
module rtos_tick_delay_manager_core (
  input logic clk,
  input logic rst,
  rtdm_req_if.sink req,
  rtdm_rsp_if.source rsp,
  input logic cfg_we,
  input logic [rtdm_pkg::CfgIdxBits-1:0] cfg_index,
  input logic [rtdm_pkg::CfgDataBits-1:0] cfg_data
);
  import rtdm_pkg::*;
  cmd_t cmd;
  sts_t sts;

  rtdm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  rtdm_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
  );
endmodule
